// ===== rtl/tscl_pkg.sv =====
// ----------------------------------------------------------------------------
// tscl_pkg
// Types and codes shared by the two-stack cursor list block.
// ----------------------------------------------------------------------------
package tscl_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_MOVE_RL = 2'd1,
		ACT_MOVE_LR = 2'd2,
		ACT_REMOVE  = 2'd3
	} act_code_t;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// where the active value comes from once the command has run
	typedef enum logic [2:0] {
		SRC_KEEP,
		SRC_VAL,
		SRC_MOVED,
		SRC_READ,
		SRC_ZERO
	} act_src_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_RSRC,
		BS_WR,
		BS_RACT,
		BS_FIN
	} back_state_t;

	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		logic       wr_from_rd;
		act_src_t   src;
		logic [1:0] status;
		logic       empty;
	} ctl_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] car_value;
	} in_t;

	typedef struct packed {
		logic [15:0] active_value;
		logic        active_valid;
		logic        list_empty;
		logic [1:0]  status;
	} out_t;

endpackage

// ===== rtl/tscl_fifo.sv =====
// ----------------------------------------------------------------------------
// tscl_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tscl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/tscl_front.sv =====
// ----------------------------------------------------------------------------
// tscl_front
// Accepts items, tracks stack depths and turns each item into a store command.
// ----------------------------------------------------------------------------
module tscl_front #(
	parameter int CAPACITY = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  tscl_pkg::in_t                   item,
	input  logic                            q_full,
	output logic                            push,
	output tscl_pkg::ctl_t                  ctl,
	output logic [$clog2(CAPACITY)-1:0]     rd_addr,
	output logic [$clog2(CAPACITY)-1:0]     wr_addr,
	output logic [$clog2(CAPACITY)-1:0]     act_addr,
	output logic [15:0]                     value
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0] lc_q, rc_q, lc_n, rc_n;
	logic [CW:0]   total;
	logic [CW-1:0] rtop_cur, rtop_inc, rtop_dec, lm1, lm2;

	assign item_ready = !q_full;
	assign push       = item_valid && item_ready;
	assign value      = item.car_value;

	assign total    = {1'b0, lc_q} + {1'b0, rc_q};
	assign rtop_cur = CAP_C - rc_q;
	assign rtop_inc = rtop_cur - CW'(1);
	assign rtop_dec = rtop_cur + CW'(1);
	assign lm1      = lc_q - CW'(1);
	assign lm2      = lc_q - CW'(2);

	always_comb begin
		ctl.rd_en      = 1'b0;
		ctl.wr_en      = 1'b0;
		ctl.wr_from_rd = 1'b0;
		ctl.src        = tscl_pkg::SRC_KEEP;
		ctl.status     = tscl_pkg::ST_DONE;
		rd_addr        = '0;
		wr_addr        = '0;
		act_addr       = '0;
		lc_n           = lc_q;
		rc_n           = rc_q;
		case (tscl_pkg::act_code_t'(item.action))
			tscl_pkg::ACT_INSERT: begin
				if (total >= (CW + 1)'(CAPACITY)) begin
					ctl.status = tscl_pkg::ST_FULL;
				end else begin
					rc_n      = rc_q + CW'(1);
					ctl.wr_en = 1'b1;
					wr_addr   = rtop_inc[AW-1:0];
					ctl.src   = tscl_pkg::SRC_VAL;
				end
			end
			tscl_pkg::ACT_MOVE_RL: begin
				if (rc_q == '0) begin
					ctl.status = tscl_pkg::ST_IGNORED;
				end else begin
					ctl.rd_en      = 1'b1;
					ctl.wr_en      = 1'b1;
					ctl.wr_from_rd = 1'b1;
					rd_addr        = rtop_cur[AW-1:0];
					wr_addr        = lc_q[AW-1:0];
					rc_n           = rc_q - CW'(1);
					lc_n           = lc_q + CW'(1);
					if (rc_q != CW'(1)) begin
						ctl.src  = tscl_pkg::SRC_READ;
						act_addr = rtop_dec[AW-1:0];
					end else begin
						ctl.src = tscl_pkg::SRC_MOVED;
					end
				end
			end
			tscl_pkg::ACT_MOVE_LR: begin
				if (lc_q == '0) begin
					ctl.status = tscl_pkg::ST_IGNORED;
				end else begin
					ctl.rd_en      = 1'b1;
					ctl.wr_en      = 1'b1;
					ctl.wr_from_rd = 1'b1;
					rd_addr        = lm1[AW-1:0];
					wr_addr        = rtop_inc[AW-1:0];
					lc_n           = lc_q - CW'(1);
					rc_n           = rc_q + CW'(1);
					ctl.src        = tscl_pkg::SRC_MOVED;
				end
			end
			tscl_pkg::ACT_REMOVE: begin
				if (rc_q != '0) begin
					rc_n = rc_q - CW'(1);
					if (rc_q != CW'(1)) begin
						ctl.src  = tscl_pkg::SRC_READ;
						act_addr = rtop_dec[AW-1:0];
					end else if (lc_q != '0) begin
						ctl.src  = tscl_pkg::SRC_READ;
						act_addr = lm1[AW-1:0];
					end else begin
						ctl.src = tscl_pkg::SRC_ZERO;
					end
				end else if (lc_q != '0) begin
					lc_n = lc_q - CW'(1);
					if (lc_q != CW'(1)) begin
						ctl.src  = tscl_pkg::SRC_READ;
						act_addr = lm2[AW-1:0];
					end else begin
						ctl.src = tscl_pkg::SRC_ZERO;
					end
				end else begin
					ctl.status = tscl_pkg::ST_IGNORED;
				end
			end
			default: begin
				ctl.status = tscl_pkg::ST_IGNORED;
			end
		endcase
		ctl.empty = (lc_n == '0) && (rc_n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0;
			rc_q <= '0;
		end else if (push) begin
			lc_q <= lc_n;
			rc_q <= rc_n;
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total <= (CW + 1)'(CAPACITY))
		else $error("stack depths exceed the store");

endmodule

// ===== rtl/tscl_back.sv =====
// ----------------------------------------------------------------------------
// tscl_back
// Runs store commands on the single-port element store and forms results.
// ----------------------------------------------------------------------------
module tscl_back #(
	parameter int CAPACITY    = 256,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  tscl_pkg::ctl_t              ctl,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [$clog2(CAPACITY)-1:0] act_addr,
	input  logic [15:0]                 value,
	output logic                        result_valid,
	input  logic                        result_ready,
	output tscl_pkg::out_t              result
);

	localparam int AW = $clog2(CAPACITY);

	tscl_pkg::back_state_t state_q, state_n;

	tscl_pkg::ctl_t         ctl_q;
	logic [AW-1:0]          rd_addr_q, wr_addr_q, act_addr_q;
	logic [15:0]            val_q;
	logic [VALUE_WIDTH-1:0] active_q, act_n;
	logic [VALUE_WIDTH-1:0] store_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] rdata_q, mem_wdata;
	logic [AW-1:0]          mem_addr;
	logic                   mem_re, mem_we, out_load;
	logic                   out_valid_q;
	tscl_pkg::out_t         out_q, res;

	always_comb begin
		state_n = state_q;
		case (state_q)
			tscl_pkg::BS_IDLE: begin
				if (q_valid) begin
					if (ctl.rd_en) begin
						state_n = tscl_pkg::BS_RSRC;
					end else if (ctl.wr_en) begin
						state_n = tscl_pkg::BS_WR;
					end else if (ctl.src == tscl_pkg::SRC_READ) begin
						state_n = tscl_pkg::BS_RACT;
					end else begin
						state_n = tscl_pkg::BS_FIN;
					end
				end
			end
			tscl_pkg::BS_RSRC: begin
				state_n = tscl_pkg::BS_WR;
			end
			tscl_pkg::BS_WR: begin
				state_n = (ctl_q.src == tscl_pkg::SRC_READ) ? tscl_pkg::BS_RACT
				                                          : tscl_pkg::BS_FIN;
			end
			tscl_pkg::BS_RACT: begin
				state_n = tscl_pkg::BS_FIN;
			end
			tscl_pkg::BS_FIN: begin
				if (out_load) begin
					state_n = tscl_pkg::BS_IDLE;
				end
			end
			default: begin
				state_n = tscl_pkg::BS_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = rd_addr_q;
		out_load  = 1'b0;
		mem_wdata = ctl_q.wr_from_rd ? rdata_q : VALUE_WIDTH'(val_q);
		case (state_q)
			tscl_pkg::BS_IDLE: begin
				q_pop = q_valid;
			end
			tscl_pkg::BS_RSRC: begin
				mem_re = 1'b1;
			end
			tscl_pkg::BS_WR: begin
				mem_we   = 1'b1;
				mem_addr = wr_addr_q;
			end
			tscl_pkg::BS_RACT: begin
				mem_re   = 1'b1;
				mem_addr = act_addr_q;
			end
			tscl_pkg::BS_FIN: begin
				out_load = !out_valid_q || result_ready;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (ctl_q.src)
			tscl_pkg::SRC_VAL:   act_n = VALUE_WIDTH'(val_q);
			tscl_pkg::SRC_MOVED: act_n = rdata_q;
			tscl_pkg::SRC_READ:  act_n = rdata_q;
			tscl_pkg::SRC_ZERO:  act_n = '0;
			default:             act_n = active_q;
		endcase
		res.active_value = 16'(act_n);
		res.active_valid = !ctl_q.empty;
		res.list_empty   = ctl_q.empty;
		res.status       = ctl_q.status;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= store_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q      <= ctl;
			rd_addr_q  <= rd_addr;
			wr_addr_q  <= wr_addr;
			act_addr_q <= act_addr;
			val_q      <= value;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tscl_pkg::BS_IDLE;
			out_valid_q <= 1'b0;
			active_q    <= '0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
				active_q    <= act_n;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.list_empty |->
			!result.active_valid && (result.active_value == '0))
		else $error("empty list reports an active value");

	a_keep_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (ctl_q.status != tscl_pkg::ST_DONE) |=> active_q == $past(active_q))
		else $error("ignored or rejected item changed the active value");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != tscl_pkg::BS_IDLE))
		else $error("command popped but sequencer stayed idle");

endmodule

// ===== rtl/two_stack_cursor_list.sv =====
// ----------------------------------------------------------------------------
// two_stack_cursor_list
// Cursor list kept as a left and a right stack in one shared element store.
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+----------------------------------
//  item     | item_valid   | item_ready   | item   (action, car_value)
//  result   | result_valid | result_ready | result (active_value, active_valid,
//           |              |              |         list_empty, status)
//
//  An item runs through the back sequencer with one state per access to the single-port
//  store plus a command pop and a result state: ignored or rejected items and a remove
//  that empties the list only pop and give a result, an insert writes, a remove that
//  keeps items reads the new top, and a move reads, writes, and may read the new top.
//  The front takes items while the two-entry command queue has room.
//  Reset clears the stack depths, queue, result valid flag and held active value; the store is not cleared.
//  A stalled result holds the sequencer; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module two_stack_cursor_list #(
	parameter int CAPACITY    = 256,
	parameter int VALUE_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  tscl_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_ready,
	output tscl_pkg::out_t result
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CMD_W = $bits(tscl_pkg::ctl_t) + 3 * AW + 16;

	logic             f_push, q_full, q_valid, q_pop;
	tscl_pkg::ctl_t   f_ctl, b_ctl;
	logic [AW-1:0]    f_rd, f_wr, f_act, b_rd, b_wr, b_act;
	logic [15:0]      f_val, b_val;
	logic [CMD_W-1:0] push_data, pop_data;

	tscl_front #(
		.CAPACITY(CAPACITY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.q_full    (q_full),
		.push      (f_push),
		.ctl       (f_ctl),
		.rd_addr   (f_rd),
		.wr_addr   (f_wr),
		.act_addr  (f_act),
		.value     (f_val)
	);

	assign push_data = {f_ctl, f_rd, f_wr, f_act, f_val};

	tscl_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.din   (push_data),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (pop_data),
		.valid (q_valid)
	);

	assign {b_ctl, b_rd, b_wr, b_act, b_val} = pop_data;

	tscl_back #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.ctl         (b_ctl),
		.rd_addr     (b_rd),
		.wr_addr     (b_wr),
		.act_addr    (b_act),
		.value       (b_val),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the two-stack cursor list. A clocked driver feeds commands
// from a backlog queue and a shadow model of both stacks predicts every
// result. A clocked monitor compares each result transfer with the oldest
// prediction. Phases vary sender and receiver idling and the action mix,
// fill the store to the point of rejection and drain it back to empty.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CAP = 256;
	localparam int VW  = 16;

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           item_valid   = 1'b0;
	logic           item_ready;
	tscl_pkg::in_t  item         = '0;
	logic           result_valid;
	logic           result_ready = 1'b0;
	tscl_pkg::out_t result;

	two_stack_cursor_list #(
		.CAPACITY(CAP),
		.VALUE_WIDTH(VW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the stacks
	logic [VW-1:0] shadow_store [CAP];
	int unsigned   left_depth  = 0;
	int unsigned   right_depth = 0;

	tscl_pkg::in_t  cmd_backlog[$];
	tscl_pkg::out_t cursor_expect_q[$];
	int   mismatches   = 0;
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	logic hold_request = 1'b0;
	logic rx_hold      = 1'b0;

	function automatic tscl_pkg::out_t predict_cursor(tscl_pkg::in_t it);
		tscl_pkg::out_t r;
		logic [VW-1:0] moved;
		r = '0;
		r.status = tscl_pkg::ST_DONE;
		case (tscl_pkg::act_code_t'(it.action))
			tscl_pkg::ACT_INSERT: begin
				if (left_depth + right_depth >= CAP) begin
					r.status = tscl_pkg::ST_FULL;
				end else begin
					right_depth++;
					shadow_store[CAP - right_depth] = it.car_value[VW-1:0];
				end
			end
			tscl_pkg::ACT_MOVE_RL: begin
				if (right_depth == 0) begin
					r.status = tscl_pkg::ST_IGNORED;
				end else begin
					moved = shadow_store[CAP - right_depth];
					right_depth--;
					shadow_store[left_depth] = moved;
					left_depth++;
				end
			end
			tscl_pkg::ACT_MOVE_LR: begin
				if (left_depth == 0) begin
					r.status = tscl_pkg::ST_IGNORED;
				end else begin
					moved = shadow_store[left_depth - 1];
					left_depth--;
					right_depth++;
					shadow_store[CAP - right_depth] = moved;
				end
			end
			default: begin
				if (right_depth != 0) begin
					right_depth--;
				end else if (left_depth != 0) begin
					left_depth--;
				end else begin
					r.status = tscl_pkg::ST_IGNORED;
				end
			end
		endcase
		if (right_depth != 0) begin
			r.active_value = shadow_store[CAP - right_depth];
			r.active_valid = 1'b1;
		end else if (left_depth != 0) begin
			r.active_value = shadow_store[left_depth - 1];
			r.active_valid = 1'b1;
		end
		r.list_empty = (left_depth == 0 && right_depth == 0);
		return r;
	endfunction

	task automatic compare_result(tscl_pkg::out_t got);
		tscl_pkg::out_t want;
		if (cursor_expect_q.size() == 0) begin
			$error("unexpected result transfer: %p", got);
			mismatches++;
		end else begin
			want = cursor_expect_q.pop_front();
			if (got.active_value !== want.active_value) begin
				$error("active_value: expected %h, got %h",
					want.active_value, got.active_value);
				mismatches++;
			end
			if (got.active_valid !== want.active_valid) begin
				$error("active_valid: expected %b, got %b",
					want.active_valid, got.active_valid);
				mismatches++;
			end
			if (got.list_empty !== want.list_empty) begin
				$error("list_empty: expected %b, got %b",
					want.list_empty, got.list_empty);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && item_ready)
				cursor_expect_q.push_back(predict_cursor(item));
			if (!item_valid || item_ready) begin
				if (cmd_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					item       <= cmd_backlog.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready)
				compare_result(result);
			result_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off
	initial begin
		wait (hold_request);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic tscl_pkg::in_t make_cmd(logic [1:0] act, logic [15:0] val);
		tscl_pkg::in_t it;
		it.action    = act;
		it.car_value = val;
		return it;
	endfunction

	function automatic tscl_pkg::in_t rand_cmd(int w_ins, int w_rl, int w_lr);
		int pick;
		logic [1:0] act;
		pick = $urandom_range(99);
		if (pick < w_ins)
			act = tscl_pkg::ACT_INSERT;
		else if (pick < w_ins + w_rl)
			act = tscl_pkg::ACT_MOVE_RL;
		else if (pick < w_ins + w_rl + w_lr)
			act = tscl_pkg::ACT_MOVE_LR;
		else
			act = tscl_pkg::ACT_REMOVE;
		return make_cmd(act, 16'($urandom));
	endfunction

	task automatic drain_all();
		while (cmd_backlog.size() > 0 || item_valid || cursor_expect_q.size() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(int n, int w_ins, int w_rl, int w_lr, int tx_pct, int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (n) cmd_backlog.push_back(rand_cmd(w_ins, w_rl, w_lr));
		drain_all();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty-list actions, extreme values, moves both ways
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_REMOVE, 16'h0000));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_MOVE_RL, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_MOVE_LR, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_INSERT, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_INSERT, 16'h0000));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_INSERT, 16'hA5A5));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_INSERT, 16'h5A5A));
		repeat (3) cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_MOVE_RL, 16'h0000));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_MOVE_LR, 16'h0000));
		repeat (3) cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_MOVE_RL, 16'h0000));
		repeat (2) cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_REMOVE, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_INSERT, 16'h8001));
		repeat (4) cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_REMOVE, 16'h0000));
		cmd_backlog.push_back(make_cmd(tscl_pkg::ACT_MOVE_LR, 16'h0000));
		drain_all();

		run_phase(100, 35, 25, 25, 0, 0);
		// fill past capacity so inserts get rejected
		run_phase(350, 85, 5, 5, 80, 0);
		run_phase(100, 40, 25, 25, 0, 80);
		// drain back to empty
		run_phase(340, 0, 10, 10, 9, 9);

		hold_request = 1'b1;
		run_phase(100, 35, 25, 25, 0, 0);

		repeat (20) @(posedge clk);
		if (mismatches == 0 && cursor_expect_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tscl_pkg.sv
rtl/tscl_fifo.sv
rtl/tscl_front.sv
rtl/tscl_back.sv
rtl/two_stack_cursor_list.sv
sim/tb_top.sv
